FILE: hdl/alr_pkg.sv
// ----------------------------------------------------------------------------
// Antialiased line rasterizer package
// Default sizes, full brightness level, operation codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package alr_pkg;

  localparam int unsigned CoordBitsDefault = 10;
  localparam int unsigned FracBitsDefault  = 16;

  localparam logic [7:0] FullLevel = 8'd255;

  localparam logic OpBegin = 1'b0;
  localparam logic OpStep  = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StSetup,
    StDivide,
    StFirst,
    StNoPixel,
    StAdvance,
    StLower,
    StUpper,
    StFar
  } alr_state_e;

endpackage

`default_nettype wire

FILE: hdl/antialiased_line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// Antialiased line rasterizer core
// Wu-style line drawing: one begin transaction sets up a line, each step
// transaction on an active line advances one major-axis column and yields one or two pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries op_i and the two endpoints.
//   op_i = OpBegin starts a line and yields the first endpoint at full level;
//   op_i = OpStep yields the pixels of the next column, the far endpoint with
//   line_done_o set, or a single no_pixel_o result when no line is active.
//   Output channel (out_valid_o/out_ready_i) carries one pixel per
//   transaction through a single output register; last_of_run_o marks the
//   final result of each input transaction.
//   Timing: a begin holds in_ready_o low from acceptance until the restoring
//   slope divider, which retires one quotient bit per cycle on the shared
//   adder, has finished and the first endpoint is loaded. A step whose column
//   reaches the upper pixel passes through advance, lower and upper states,
//   even if a near-zero lower level is dropped; one with only the lower pixel
//   due passes through advance and lower; the far endpoint or a step without
//   a line uses only the far or no-pixel state. The first result appears in
//   the cycle after it is formed.
//   Reset clears the line state and drops any pending result; a receiver
//   stall holds the result register and the sequencer waits for the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module antialiased_line_rasterizer_core #(
  parameter int unsigned CoordBits = alr_pkg::CoordBitsDefault,
  parameter int unsigned FracBits  = alr_pkg::FracBitsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 op_i,
  input  wire logic [CoordBits-1:0] start_x_i,
  input  wire logic [CoordBits-1:0] start_y_i,
  input  wire logic [CoordBits-1:0] end_x_i,
  input  wire logic [CoordBits-1:0] end_y_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [CoordBits-1:0]      pixel_x_o,
  output logic [CoordBits-1:0]      pixel_y_o,
  output logic [7:0]                brightness_o,
  output logic                      no_pixel_o,
  output logic                      last_of_run_o,
  output logic                      line_done_o
);

  import alr_pkg::*;

  localparam int unsigned IcptW = CoordBits + FracBits + 1;
  localparam int unsigned SlopeW = FracBits + 2;
  localparam int unsigned MagW = FracBits + 1;
  localparam int unsigned RemW = CoordBits + 1;
  localparam int unsigned CntW = $clog2(FracBits + 1);
  localparam int unsigned ProdW = FracBits + 9;
  localparam logic [CntW-1:0] LastIter = CntW'(FracBits);

  // Sequencer
  alr_state_e state_q, state_d;

  // Line state
  logic                 line_active_q, line_active_d;
  logic                 steep_q, steep_d;
  logic [CoordBits-1:0] column_q, column_d;
  logic [CoordBits-1:0] last_column_q, last_column_d;
  logic [IcptW-1:0]     intercept_q, intercept_d;
  logic [SlopeW-1:0]    slope_q, slope_d;
  logic [CoordBits-1:0] far_minor_q, far_minor_d;

  // Captured endpoints and divider
  logic [CoordBits-1:0] ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic [RemW-1:0]      rem_q, rem_d;
  logic [FracBits-1:0]  quo_q, quo_d;
  logic [CoordBits-1:0] div_q, div_d;
  logic                 neg_q, neg_d;
  logic [CntW-1:0]      cnt_q, cnt_d;

  // Result register
  logic                 out_valid_q, out_valid_d;
  logic [CoordBits-1:0] pixel_x_q, pixel_x_d, pixel_y_q, pixel_y_d;
  logic [7:0]           brightness_q, brightness_d;
  logic                 no_pixel_q, no_pixel_d;
  logic                 last_q, last_d;
  logic                 done_q, done_d;

  // Shared adder
  logic [IcptW-1:0] alu_a, alu_b;
  logic             alu_cin;
  logic [IcptW:0]   alu_sum;

  // Setup, step and brightness terms
  logic [CoordBits-1:0] adx, ady, p_maj0, p_min0, p_maj1, p_min1;
  logic [CoordBits-1:0] maj0, min0, maj1, min1, dmin, dmaj;
  logic                 steep_c, swap_c, neg_c;
  logic [CoordBits:0]   col_next;
  logic                 interior;
  logic                 in_acc, out_free, div_ge, div_last;
  logic [RemW-1:0]      rem_sel;
  logic [MagW-1:0]      mag;
  logic [FracBits-1:0]  frac;
  logic [FracBits:0]    inv;
  logic [ProdW-1:0]     lo_prod;
  logic [ProdW-2:0]     hi_prod;
  logic [7:0]           lo_level, hi_level;
  logic [CoordBits-1:0] whole;

  // Result load request
  logic                 ld_out;
  logic [CoordBits-1:0] ld_major, ld_minor;
  logic [7:0]           ld_level;
  logic                 ld_nopix, ld_last, ld_done;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign div_ge   = alu_sum[IcptW];
  assign div_last = (cnt_q == LastIter);

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + {{IcptW{1'b0}}, alu_cin};

  // Endpoint ordering and major-axis choice
  always_comb begin
    adx     = (ax_q > bx_q) ? ax_q - bx_q : bx_q - ax_q;
    ady     = (ay_q > by_q) ? ay_q - by_q : by_q - ay_q;
    steep_c = ady > adx;
    p_maj0  = steep_c ? ay_q : ax_q;
    p_min0  = steep_c ? ax_q : ay_q;
    p_maj1  = steep_c ? by_q : bx_q;
    p_min1  = steep_c ? bx_q : by_q;
    swap_c  = p_maj0 > p_maj1;
    maj0    = swap_c ? p_maj1 : p_maj0;
    min0    = swap_c ? p_min1 : p_min0;
    maj1    = swap_c ? p_maj0 : p_maj1;
    min1    = swap_c ? p_min0 : p_min1;
    neg_c   = min1 < min0;
    dmin    = neg_c ? min0 - min1 : min1 - min0;
    dmaj    = maj1 - maj0;
  end

  // Column test and coverage levels
  always_comb begin
    col_next = {1'b0, column_q} + (CoordBits + 1)'(1);
    interior = col_next < {1'b0, last_column_q};
    frac     = intercept_q[FracBits-1:0];
    whole    = intercept_q[FracBits+CoordBits-1:FracBits];
    inv      = {1'b1, {FracBits{1'b0}}} - {1'b0, frac};
    lo_prod  = {inv, 8'd0} - {8'd0, inv};
    hi_prod  = {frac, 8'd0} - {8'd0, frac};
    lo_level = lo_prod[FracBits+7:FracBits];
    hi_level = hi_prod[FracBits+7:FracBits];
    rem_sel  = div_ge ? alu_sum[RemW-1:0] : rem_q;
    mag      = (div_q == '0) ? '0 : {quo_q, div_ge};
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (op_i == OpBegin) begin
            state_d = StSetup;
          end else if (!line_active_q) begin
            state_d = StNoPixel;
          end else if (interior) begin
            state_d = StAdvance;
          end else begin
            state_d = StFar;
          end
        end
      end
      StSetup:   state_d = StDivide;
      StDivide:  if (div_last) state_d = StFirst;
      StFirst:   if (out_free) state_d = StIdle;
      StNoPixel: if (out_free) state_d = StIdle;
      StAdvance: state_d = StLower;
      StLower: begin
        if (lo_level == '0) begin
          state_d = StUpper;
        end else if (out_free) begin
          state_d = (hi_level == '0) ? StIdle : StUpper;
        end
      end
      StUpper:   if (out_free) state_d = StIdle;
      StFar:     if (out_free) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  // Datapath control and register updates
  always_comb begin
    in_ready_o    = (state_q == StIdle);
    line_active_d = line_active_q;
    steep_d       = steep_q;
    column_d      = column_q;
    last_column_d = last_column_q;
    intercept_d   = intercept_q;
    slope_d       = slope_q;
    far_minor_d   = far_minor_q;
    ax_d          = ax_q;
    ay_d          = ay_q;
    bx_d          = bx_q;
    by_d          = by_q;
    rem_d         = rem_q;
    quo_d         = quo_q;
    div_d         = div_q;
    neg_d         = neg_q;
    cnt_d         = cnt_q;

    // The adder subtracts the divisor while dividing, else adds the slope
    if (state_q == StDivide) begin
      alu_a   = {{(IcptW-RemW){1'b0}}, rem_q};
      alu_b   = ~{{(IcptW-CoordBits){1'b0}}, div_q};
      alu_cin = 1'b1;
    end else begin
      alu_a   = intercept_q;
      alu_b   = {{(IcptW-SlopeW){slope_q[SlopeW-1]}}, slope_q};
      alu_cin = 1'b0;
    end

    ld_out   = 1'b0;
    ld_major = column_q;
    ld_minor = whole;
    ld_level = FullLevel;
    ld_nopix = 1'b0;
    ld_last  = 1'b1;
    ld_done  = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          ax_d = start_x_i;
          ay_d = start_y_i;
          bx_d = end_x_i;
          by_d = end_y_i;
        end
      end
      StSetup: begin
        steep_d       = steep_c;
        column_d      = maj0;
        last_column_d = maj1;
        far_minor_d   = min1;
        intercept_d   = {1'b0, min0, {FracBits{1'b0}}};
        rem_d         = {1'b0, dmin};
        div_d         = dmaj;
        neg_d         = neg_c;
        cnt_d         = '0;
        line_active_d = 1'b1;
      end
      StDivide: begin
        // One quotient bit per cycle, remainder shifted for the next
        rem_d = {rem_sel[CoordBits-1:0], 1'b0};
        quo_d = {quo_q[FracBits-2:0], div_ge};
        cnt_d = cnt_q + CntW'(1);
        if (div_last) begin
          slope_d = neg_q ? SlopeW'(0) - {1'b0, mag} : {1'b0, mag};
        end
      end
      StFirst: begin
        ld_out = out_free;
      end
      StNoPixel: begin
        ld_out   = out_free;
        ld_major = '0;
        ld_minor = '0;
        ld_level = '0;
        ld_nopix = 1'b1;
      end
      StAdvance: begin
        column_d    = col_next[CoordBits-1:0];
        intercept_d = alu_sum[IcptW-1:0];
      end
      StLower: begin
        ld_out   = out_free && (lo_level != '0);
        ld_level = lo_level;
        ld_last  = (hi_level == '0);
      end
      StUpper: begin
        ld_out   = out_free;
        ld_minor = whole + CoordBits'(1);
        ld_level = hi_level;
      end
      StFar: begin
        ld_out   = out_free;
        ld_major = last_column_q;
        ld_minor = far_minor_q;
        ld_done  = 1'b1;
        if (out_free) begin
          line_active_d = 1'b0;
          column_d      = last_column_q;
        end
      end
      default: begin
        ld_out = 1'b0;
      end
    endcase

    // Hold the result until taken, then refill or drop
    out_valid_d  = out_valid_q && !out_ready_i;
    pixel_x_d    = pixel_x_q;
    pixel_y_d    = pixel_y_q;
    brightness_d = brightness_q;
    no_pixel_d   = no_pixel_q;
    last_d       = last_q;
    done_d       = done_q;
    if (ld_out) begin
      out_valid_d  = 1'b1;
      pixel_x_d    = steep_q ? ld_minor : ld_major;
      pixel_y_d    = steep_q ? ld_major : ld_minor;
      brightness_d = ld_level;
      no_pixel_d   = ld_nopix;
      last_d       = ld_last;
      done_d       = ld_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      line_active_q <= 1'b0;
      steep_q       <= 1'b0;
      column_q      <= '0;
      last_column_q <= '0;
      intercept_q   <= '0;
      slope_q       <= '0;
      far_minor_q   <= '0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      line_active_q <= line_active_d;
      steep_q       <= steep_d;
      column_q      <= column_d;
      last_column_q <= last_column_d;
      intercept_q   <= intercept_d;
      slope_q       <= slope_d;
      far_minor_q   <= far_minor_d;
      cnt_q         <= cnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q         <= ax_d;
    ay_q         <= ay_d;
    bx_q         <= bx_d;
    by_q         <= by_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    div_q        <= div_d;
    neg_q        <= neg_d;
    pixel_x_q    <= pixel_x_d;
    pixel_y_q    <= pixel_y_d;
    brightness_q <= brightness_d;
    no_pixel_q   <= no_pixel_d;
    last_q       <= last_d;
    done_q       <= done_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pixel_x_q;
  assign pixel_y_o     = pixel_y_q;
  assign brightness_o  = brightness_q;
  assign no_pixel_o    = no_pixel_q;
  assign last_of_run_o = last_q;
  assign line_done_o   = done_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again while a transaction is in progress");

  a_nopix_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_pixel_o |-> last_of_run_o && !line_done_o && brightness_o == '0)
    else $error("malformed no-pixel result");

  a_done_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_done_o |-> last_of_run_o && brightness_o == FullLevel)
    else $error("far endpoint result not at full level or not last");

  a_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(line_active_q) |-> out_valid_o && line_done_o)
    else $error("line ended without emitting the far endpoint");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDivide |-> cnt_q <= LastIter)
    else $error("divider iteration count overran");

endmodule

`default_nettype wire

FILE: dv/alr_pixel_checker.sv
// ----------------------------------------------------------------------------
// Antialiased line rasterizer pixel checker
// Watches both channels of the core, predicts the pixels of every accepted
// input transaction and compares each accepted output transaction with the
// oldest predicted pixel, field by field.
// ----------------------------------------------------------------------------
module alr_pixel_checker #(
  parameter int unsigned CoordBits = alr_pkg::CoordBitsDefault,
  parameter int unsigned FracBits  = alr_pkg::FracBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 op_i,
  input  logic [CoordBits-1:0] start_x_i,
  input  logic [CoordBits-1:0] start_y_i,
  input  logic [CoordBits-1:0] end_x_i,
  input  logic [CoordBits-1:0] end_y_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [CoordBits-1:0] pixel_x_i,
  input  logic [CoordBits-1:0] pixel_y_i,
  input  logic [7:0]           brightness_i,
  input  logic                 no_pixel_i,
  input  logic                 last_of_run_i,
  input  logic                 line_done_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  import alr_pkg::*;

  localparam int unsigned IcptBits  = CoordBits + FracBits + 1;
  localparam int unsigned SlopeBits = FracBits + 2;

  typedef struct packed {
    logic [CoordBits-1:0] px;
    logic [CoordBits-1:0] py;
    logic [7:0]           level;
    logic                 no_pixel;
    logic                 last;
    logic                 done;
  } pixel_t;

  pixel_t expected_pixels[$];

  logic                 line_on;
  logic                 steep_q;
  logic [CoordBits-1:0] col_q;
  logic [CoordBits-1:0] end_col_q;
  logic [IcptBits-1:0]  icpt_q;
  logic [SlopeBits-1:0] slope_q;
  logic [CoordBits-1:0] end_minor_q;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic push_pixel(input logic [63:0] major, input logic [63:0] minor,
                            input logic [7:0] level, input logic last,
                            input logic done);
    pixel_t p;
    p.px       = steep_q ? minor[CoordBits-1:0] : major[CoordBits-1:0];
    p.py       = steep_q ? major[CoordBits-1:0] : minor[CoordBits-1:0];
    p.level    = level;
    p.no_pixel = 1'b0;
    p.last     = last;
    p.done     = done;
    expected_pixels.push_back(p);
  endtask

  task automatic rasterize(input logic op, input logic [CoordBits-1:0] ax,
                           input logic [CoordBits-1:0] ay,
                           input logic [CoordBits-1:0] bx,
                           input logic [CoordBits-1:0] by);
    logic [63:0] x0, y0, x1, y1, adx, ady;
    logic [63:0] maj0, min0, maj1, min1, tmp, dmaj, dmin, mag;
    logic [63:0] sx, fr, whole, lo, hi;
    logic        neg;
    pixel_t      idle_px;
    x0 = ax;
    y0 = ay;
    x1 = bx;
    y1 = by;
    if (op == OpBegin) begin
      adx     = x0 > x1 ? x0 - x1 : x1 - x0;
      ady     = y0 > y1 ? y0 - y1 : y1 - y0;
      steep_q = ady > adx;
      if (steep_q) begin
        maj0 = y0; min0 = x0; maj1 = y1; min1 = x1;
      end else begin
        maj0 = x0; min0 = y0; maj1 = x1; min1 = y1;
      end
      // walk the major axis upwards
      if (maj0 > maj1) begin
        tmp = maj0; maj0 = maj1; maj1 = tmp;
        tmp = min0; min0 = min1; min1 = tmp;
      end
      dmaj        = maj1 - maj0;
      neg         = min1 < min0;
      dmin        = neg ? min0 - min1 : min1 - min0;
      mag         = (dmaj == 0) ? 64'd0 : (dmin << FracBits) / dmaj;
      tmp         = neg ? 64'd0 - mag : mag;
      slope_q     = tmp[SlopeBits-1:0];
      col_q       = maj0[CoordBits-1:0];
      end_col_q   = maj1[CoordBits-1:0];
      end_minor_q = min1[CoordBits-1:0];
      tmp         = min0 << FracBits;
      icpt_q      = tmp[IcptBits-1:0];
      line_on     = 1'b1;
      push_pixel(maj0, min0, FullLevel, 1'b1, 1'b0);
    end else if (!line_on) begin
      idle_px          = '0;
      idle_px.no_pixel = 1'b1;
      idle_px.last     = 1'b1;
      expected_pixels.push_back(idle_px);
    end else begin
      tmp = col_q;
      x1  = end_col_q;
      if (tmp + 64'd1 < x1) begin
        sx     = {{(64-SlopeBits){slope_q[SlopeBits-1]}}, slope_q};
        col_q  = col_q + 1'b1;
        icpt_q = icpt_q + sx[IcptBits-1:0];
        fr     = icpt_q[FracBits-1:0];
        whole  = icpt_q >> FracBits;
        lo     = (((64'd1 << FracBits) - fr) * 64'd255) >> FracBits;
        hi     = (fr * 64'd255) >> FracBits;
        tmp    = col_q;
        // drop either pixel when its level truncates to zero
        if (lo != 0) push_pixel(tmp, whole, lo[7:0], hi == 0, 1'b0);
        if (hi != 0) push_pixel(tmp, whole + 64'd1, hi[7:0], 1'b1, 1'b0);
      end else begin
        push_pixel(x1, {{(64-CoordBits){1'b0}}, end_minor_q}, FullLevel, 1'b1, 1'b1);
        col_q   = end_col_q;
        line_on = 1'b0;
      end
    end
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      line_on     = 1'b0;
      steep_q     = 1'b0;
      col_q       = '0;
      end_col_q   = '0;
      icpt_q      = '0;
      slope_q     = '0;
      end_minor_q = '0;
      expected_pixels.delete();
      pending_o   = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        rasterize(op_i, start_x_i, start_y_i, end_x_i, end_y_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d level=%0d",
                   $time, pixel_x_i, pixel_y_i, brightness_i);
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_x", want.px, pixel_x_i);
          check_field("pixel_y", want.py, pixel_y_i);
          check_field("brightness", want.level, brightness_i);
          check_field("no_pixel", want.no_pixel, no_pixel_i);
          check_field("last_of_run", want.last, last_of_run_i);
          check_field("line_done", want.done, line_done_i);
        end
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule

FILE: dv/tb_antialiased_line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// Antialiased line rasterizer core testbench
// Drives directed and random line transactions with random idling on both
// channels, one long receiver hold-off and one drain pause, and reports the
// verdict from the pixel checker.
// ----------------------------------------------------------------------------
module tb_antialiased_line_rasterizer_core;
  import alr_pkg::*;

  localparam int unsigned CoordBits  = alr_pkg::CoordBitsDefault;
  localparam int unsigned FracBits   = alr_pkg::FracBitsDefault;
  localparam int          CoordMax   = (1 << CoordBits) - 1;
  localparam int unsigned TotalItems = 850;
  localparam int unsigned DrainAt    = 500;
  localparam int unsigned HoldAt     = 120;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned TailCycles = 40;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_op       = 1'b0;
  logic [CoordBits-1:0] in_start_x  = '0;
  logic [CoordBits-1:0] in_start_y  = '0;
  logic [CoordBits-1:0] in_end_x    = '0;
  logic [CoordBits-1:0] in_end_y    = '0;
  logic                 out_ready   = 1'b0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [CoordBits-1:0] pixel_x_o;
  logic [CoordBits-1:0] pixel_y_o;
  logic [7:0]           brightness_o;
  logic                 no_pixel_o;
  logic                 last_of_run_o;
  logic                 line_done_o;
  int unsigned          fail_count;
  int unsigned          pending;
  int unsigned          items_sent  = 0;
  int unsigned          idle_cycles = 0;
  logic                 send_fast   = 1'b0;

  always #5 clk_i = ~clk_i;

  antialiased_line_rasterizer_core #(
    .CoordBits(CoordBits),
    .FracBits (FracBits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .op_i         (in_op),
    .start_x_i    (in_start_x),
    .start_y_i    (in_start_y),
    .end_x_i      (in_end_x),
    .end_y_i      (in_end_y),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .brightness_o (brightness_o),
    .no_pixel_o   (no_pixel_o),
    .last_of_run_o(last_of_run_o),
    .line_done_o  (line_done_o)
  );

  alr_pixel_checker #(
    .CoordBits(CoordBits),
    .FracBits (FracBits)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready_o),
    .op_i         (in_op),
    .start_x_i    (in_start_x),
    .start_y_i    (in_start_y),
    .end_x_i      (in_end_x),
    .end_y_i      (in_end_y),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready),
    .pixel_x_i    (pixel_x_o),
    .pixel_y_i    (pixel_y_o),
    .brightness_i (brightness_o),
    .no_pixel_i   (no_pixel_o),
    .last_of_run_i(last_of_run_o),
    .line_done_i  (line_done_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // End the run when neither channel completes a transaction for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("** antialiased_line_rasterizer_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic send_item(input logic op_v, input logic [CoordBits-1:0] ax,
                           input logic [CoordBits-1:0] ay,
                           input logic [CoordBits-1:0] bx,
                           input logic [CoordBits-1:0] by);
    int unsigned gap;
    logic        hit;
    if ($urandom_range(0, 39) == 0) send_fast = !send_fast;
    gap = send_fast ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    in_op      <= op_v;
    in_start_x <= ax;
    in_start_y <= ay;
    in_end_x   <= bx;
    in_end_y   <= by;
    // hold the transaction until the core takes it
    do begin
      @(negedge clk_i);
      hit = in_ready_o;
      @(posedge clk_i);
    end while (!hit);
    items_sent++;
    if (items_sent == DrainAt) begin
      in_valid <= 1'b0;
      wait_drained();
    end
  endtask

  task automatic send_step();
    send_item(OpStep, $urandom_range(0, CoordMax), $urandom_range(0, CoordMax),
              $urandom_range(0, CoordMax), $urandom_range(0, CoordMax));
  endtask

  task automatic run_directed();
    send_item(OpStep, CoordMax, CoordMax, CoordMax, CoordMax);
    // coincident endpoints, then the far endpoint and a step with no line
    send_item(OpBegin, 5, 5, 5, 5);
    send_item(OpStep, 0, 0, 0, 0);
    send_item(OpStep, 0, 0, 0, 0);
    // no interior columns
    send_item(OpBegin, 0, 0, 1, 0);
    send_step();
    // full-scale diagonal falling, abandoned after two columns
    send_item(OpBegin, CoordMax, 0, 0, CoordMax);
    send_step();
    send_step();
    send_item(OpBegin, 0, CoordMax, 3, 0);
    repeat (3) send_step();
    send_item(OpBegin, CoordMax, CoordMax, CoordMax - 3, CoordMax - 23);
    repeat (3) send_step();
    // flat line, upper pixel always dropped
    send_item(OpBegin, 0, 0, CoordMax, 0);
    send_step();
    send_item(OpBegin, 10, 10, 13, 12);
    repeat (3) send_step();
  endtask

  task automatic run_random();
    int   pick, reach, sx, sy, ex, ey, dmaj, full, steps;
    logic op_v;
    while (items_sent < TotalItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        op_v = $urandom_range(0, 1);
        send_item(op_v, $urandom_range(0, CoordMax), $urandom_range(0, CoordMax),
                  $urandom_range(0, CoordMax), $urandom_range(0, CoordMax));
      end else begin
        pick  = $urandom_range(0, 99);
        reach = pick < 80 ? $urandom_range(0, 12) :
                pick < 95 ? $urandom_range(0, 60) : CoordMax;
        sx = $urandom_range(0, CoordMax);
        sy = $urandom_range(0, CoordMax);
        ex = $urandom_range(sx > reach ? sx - reach : 0,
                            sx + reach > CoordMax ? CoordMax : sx + reach);
        ey = $urandom_range(sy > reach ? sy - reach : 0,
                            sy + reach > CoordMax ? CoordMax : sy + reach);
        send_item(OpBegin, sx, sy, ex, ey);
        dmaj = (sx > ex ? sx - ex : ex - sx);
        if ((sy > ey ? sy - ey : ey - sy) > dmaj) dmaj = sy > ey ? sy - ey : ey - sy;
        full = dmaj > 1 ? dmaj : 1;
        pick = $urandom_range(0, 99);
        // mostly complete lines, some overrun into idle steps, some cut short
        steps = pick < 70 ? full :
                pick < 85 ? full + $urandom_range(1, 3) : $urandom_range(0, full - 1);
        if (steps > 48) steps = 48;
        repeat (steps) send_step();
      end
    end
  endtask

  initial begin : rx_proc
    int unsigned gap;
    int unsigned taken;
    logic        fast;
    logic        hit;
    taken = 0;
    fast  = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) fast = !fast;
      gap = fast ? 0 : $urandom_range(0, 14);
      if (taken == HoldAt) gap = HoldCycles;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk_i);
        hit = out_valid_o;
        @(posedge clk_i);
      end while (!hit);
      taken++;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** antialiased_line_rasterizer_core: PASSED **");
    end else begin
      $display("** antialiased_line_rasterizer_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/alr_pkg.sv
hdl/antialiased_line_rasterizer_core.sv
dv/alr_pixel_checker.sv
dv/tb_antialiased_line_rasterizer_core.sv
